/* sv/assert_macros.svh */
// assertion macros shared by the blur engine rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GBR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gbr assertion failed");
`define GBR_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("gbr assertion failed");
`else
`define GBR_ASSERT(lbl, clk, rst_n, prop)
`define GBR_ASSERT_NR(lbl, clk, prop)
`endif
`endif

/* sv/gbr_pkg.sv */
// shared types and codes for the separable blur engine
// no dependencies
package gbr_pkg;
  localparam int CH_BITS = 8;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_RADIUS    = 3'd2;
  localparam logic [2:0] REG_TAPS_LOW  = 3'd3;
  localparam logic [2:0] REG_TAPS_HIGH = 3'd4;

  typedef struct packed {
    logic clr;
    logic acc;
  } gbr_mac_ctl_t;
endpackage

/* sv/gbr_mac.sv */
// shared multiply-accumulate unit for the three color channels
// depends on gbr_pkg
module gbr_mac import gbr_pkg::*; #(
  parameter int TAP_BITS = 16,
  parameter int ACC_BITS = 29
) (
  input  logic                  clk_i,
  input  gbr_mac_ctl_t          ctl_i,
  input  logic [3*CH_BITS-1:0]  pix_i,
  input  logic [TAP_BITS-1:0]   tap_i,
  output logic [3*CH_BITS-1:0]  res_o
);
  localparam int FRAC = TAP_BITS - 2;

  logic [ACC_BITS-1:0] acc_q [3];
  logic [ACC_BITS-1:0] acc_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_d[c] = acc_q[c];
      if (ctl_i.clr) begin
        acc_d[c] = '0;
      end else if (ctl_i.acc) begin
        acc_d[c] = acc_q[c] +
                   ACC_BITS'(pix_i[c*CH_BITS +: CH_BITS]) * ACC_BITS'(tap_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) acc_q[c] <= acc_d[c];
  end

  // truncate the fraction, saturate at full scale
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (acc_q[c][ACC_BITS-1:FRAC+CH_BITS] != '0) begin
        res_o[c*CH_BITS +: CH_BITS] = '1;
      end else begin
        res_o[c*CH_BITS +: CH_BITS] = acc_q[c][FRAC +: CH_BITS];
      end
    end
  end
endmodule

/* sv/separable_gaussian_blur_rgb.sv */
// separable gaussian blur engine, top level with frame memories and sequencer
// depends on gbr_pkg, gbr_mac and assert_macros.svh
//
// requests enter on in_valid_i/in_stall_o, results leave on out_valid_o/out_stall_i;
// every request gives exactly one result. configuration is written over the apb
// port at byte address 8*index; the user must write it while the engine is idle, since the block has no check for this.
// write request: pixel stored at the accepting edge, result valid the next cycle.
// read request: the frame read is registered in S_RPIX, then S_RESP loads the result once the output is free.
// run request: horizontal pass into the intermediate frame, then vertical pass
// back into the source frame; for each pixel, every tap is one registered frame read
// (S_RD) followed by one step of the shared multiply-accumulate unit (S_ACC),
// and S_WR then writes the result.
// one request is in work at a time; in_stall_o is high while busy or while a
// result is held by a stalled receiver. a stalled result holds its value.
// reset empties the sequencer and output register and loads the register
// defaults (64x64, radius 0, unit center tap); frame contents stay undefined
// until written.
module separable_gaussian_blur_rgb import gbr_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RADIUS = 7,
  parameter int TAP_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  pos_x_i,
  input  logic [5:0]  pos_y_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  `include "assert_macros.svh"

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int RW = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int KW = RW + 1;
  localparam int ACC_BITS = TAP_BITS + CH_BITS + $clog2(2 * MAX_RADIUS + 2);
  localparam int PW = 3 * CH_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_RPIX = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  // configuration registers
  logic [6:0]  width_q, height_q;
  logic [2:0]  radius_q;
  logic [63:0] taps_low_q, taps_high_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 7'd64;
      height_q    <= 7'd64;
      radius_q    <= 3'd0;
      taps_low_q  <= 64'd16384;
      taps_high_q <= 64'd0;
    end else if (cfg_we) begin
      unique case (paddr[5:3])
        REG_WIDTH:     width_q     <= pwdata[6:0];
        REG_HEIGHT:    height_q    <= pwdata[6:0];
        REG_RADIUS:    radius_q    <= pwdata[2:0];
        REG_TAPS_LOW:  taps_low_q  <= pwdata;
        REG_TAPS_HIGH: taps_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_WIDTH:     prdata = {57'd0, width_q};
      REG_HEIGHT:    prdata = {57'd0, height_q};
      REG_RADIUS:    prdata = {61'd0, radius_q};
      REG_TAPS_LOW:  prdata = taps_low_q;
      REG_TAPS_HIGH: prdata = taps_high_q;
      default:       prdata = '0;
    endcase
  end

  // active dimensions and radius
  logic [12:0]   w_wide, h_wide;
  logic [XW:0]   act_w;
  logic [YW:0]   act_h;
  logic [3:0]    r_wide;
  logic [RW-1:0] act_r;

  always_comb begin
    if (width_q == 7'd0) w_wide = 13'd1;
    else if (13'(width_q) > 13'(MAX_WIDTH)) w_wide = 13'(MAX_WIDTH);
    else w_wide = 13'(width_q);
    if (height_q == 7'd0) h_wide = 13'd1;
    else if (13'(height_q) > 13'(MAX_HEIGHT)) h_wide = 13'(MAX_HEIGHT);
    else h_wide = 13'(height_q);
    r_wide = (4'(radius_q) > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : 4'(radius_q);
  end
  assign act_w = w_wide[XW:0];
  assign act_h = h_wide[YW:0];
  assign act_r = r_wide[RW-1:0];

  // sequencer state
  logic [2:0]           state_q, state_d;
  logic                 pass_q, pass_d;
  logic [XW-1:0]        x_q, x_d;
  logic [YW-1:0]        y_q, y_d;
  logic signed [KW-1:0] k_q, k_d, r_s;
  logic [AW-1:0]        addr_q, addr_d;
  logic                 is_read_q, is_read_d;
  logic                 out_valid_q, out_valid_d;
  logic [PW-1:0]        out_pix_q, out_pix_d;
  logic                 status_q, status_d;

  logic          in_acc, out_free, in_frame;
  logic [AW-1:0] pos_addr;

  assign r_s      = $signed({1'b0, act_r});
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_frame = (13'(pos_x_i) < 13'(act_w)) && (13'(pos_y_i) < 13'(act_h));
  assign pos_addr = {YW'(pos_y_i), XW'(pos_x_i)};

  // clamped sample coordinates
  logic signed [15:0] sx, sy;
  logic [XW-1:0]      sx_c;
  logic [YW-1:0]      sy_c;

  always_comb begin
    sx = $signed(16'(x_q)) + 16'(k_q);
    sy = $signed(16'(y_q)) + 16'(k_q);
    if (sx < 0) sx_c = '0;
    else if (sx >= $signed(16'(act_w))) sx_c = XW'(act_w - 1'b1);
    else sx_c = sx[XW-1:0];
    if (sy < 0) sy_c = '0;
    else if (sy >= $signed(16'(act_h))) sy_c = YW'(act_h - 1'b1);
    else sy_c = sy[YW-1:0];
  end

  // tap lookup for |k|
  logic [3:0]          koff;
  logic [63:0]         tap_word, tap_shift;
  logic [TAP_BITS-1:0] tap;

  always_comb begin
    koff = (k_q < 0) ? 4'(-k_q) : 4'(k_q);
    tap_word  = koff[2] ? taps_high_q : taps_low_q;
    tap_shift = tap_word >> (TAP_BITS * int'(koff[1:0]));
    if (TAP_BITS * int'(koff[1:0]) + TAP_BITS > 64) tap = '0;
    else tap = tap_shift[TAP_BITS-1:0];
  end

  // frame memories
  logic [PW-1:0] src_mem [DEPTH];
  logic [PW-1:0] imd_mem [DEPTH];
  logic [PW-1:0] src_rdata_q, imd_rdata_q, mac_res;
  logic [AW-1:0] src_raddr, src_waddr, imd_raddr;
  logic [PW-1:0] src_wdata;
  logic          src_we, imd_we;

  assign src_raddr = (state_q == S_RD && !pass_q) ? {y_q, sx_c} : addr_q;
  assign imd_raddr = {sy_c, x_q};
  assign imd_we    = (state_q == S_WR) && !pass_q;
  assign src_we    = ((state_q == S_WR) && pass_q) ||
                     (in_acc && req_type_i == REQ_WRITE && in_frame);
  assign src_waddr = (state_q == S_WR) ? {y_q, x_q} : pos_addr;
  assign src_wdata = (state_q == S_WR) ? mac_res : {in_red_i, in_green_i, in_blue_i};

  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[src_waddr] <= src_wdata;
    src_rdata_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (imd_we) imd_mem[{y_q, x_q}] <= mac_res;
    imd_rdata_q <= imd_mem[imd_raddr];
  end

  gbr_mac_ctl_t mac_ctl;
  assign mac_ctl.clr = (state_q == S_WR) || in_acc;
  assign mac_ctl.acc = (state_q == S_ACC);

  gbr_mac #(
    .TAP_BITS (TAP_BITS),
    .ACC_BITS (ACC_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .pix_i (pass_q ? imd_rdata_q : src_rdata_q),
    .tap_i (tap),
    .res_o (mac_res)
  );

  logic last_x, last_y;
  assign last_x = ({1'b0, x_q} == act_w - 1'b1);
  assign last_y = ({1'b0, y_q} == act_h - 1'b1);

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    x_d         = x_q;
    y_d         = y_q;
    k_d         = k_q;
    addr_d      = addr_q;
    is_read_d   = is_read_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_pix_d   = out_pix_q;
    status_d    = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          addr_d    = pos_addr;
          is_read_d = 1'b0;
          status_d  = 1'b0;
          priority case (req_type_i)
            REQ_RUN: begin
              state_d = S_RD;
              pass_d  = 1'b0;
              x_d     = '0;
              y_d     = '0;
              k_d     = -r_s;
            end
            REQ_READ: begin
              if (in_frame) begin
                is_read_d = 1'b1;
                state_d   = S_RPIX;
              end else begin
                state_d  = S_RESP;
                status_d = 1'b1;
              end
            end
            default: begin
              // write and unused code answer at once
              out_valid_d = 1'b1;
              out_pix_d   = '0;
              status_d    = (req_type_i == REQ_WRITE) && !in_frame;
            end
          endcase
        end
      end
      S_RD:   state_d = S_ACC;
      S_ACC: begin
        if (k_q == r_s) begin
          state_d = S_WR;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_WR: begin
        k_d     = -r_s;
        state_d = S_RD;
        if (!last_x) begin
          x_d = x_q + 1'b1;
        end else begin
          x_d = '0;
          if (!last_y) begin
            y_d = y_q + 1'b1;
          end else begin
            y_d = '0;
            if (pass_q) state_d = S_RESP;
            else pass_d = 1'b1;
          end
        end
      end
      S_RPIX: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = is_read_q ? src_rdata_q : '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pass_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pass_q      <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    k_q       <= k_d;
    addr_q    <= addr_d;
    is_read_q <= is_read_d;
    out_pix_q <= out_pix_d;
    status_q  <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_pix_q[23:16];
  assign out_green_o = out_pix_q[15:8];
  assign out_blue_o  = out_pix_q[7:0];
  assign status_o    = status_q;

  `GBR_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q != S_IDLE) |-> in_stall_o)
  `GBR_ASSERT(a_k_range, clk_i, rst_ni, (state_q == S_ACC) |-> (k_q <= r_s && k_q >= -r_s))
  `GBR_ASSERT(a_one_frame_write, clk_i, rst_ni, !(src_we && imd_we))
endmodule
